>>> sv/cpor_pkg.sv
`default_nettype none

package cpor_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int RAD_W   = 31;
    localparam int MASS_W  = 32;
    localparam int D2_W    = 64;
    localparam int DIST_W  = 32;
    localparam int MSUM_W  = 33;
    localparam int SHARE_W = 48;   // other mass * 2^16 / mass sum stays below 2^48
    localparam int SNUM_W  = MASS_W + 16;
    localparam int UNUM_W  = DIST_W + 30;
    localparam int UNIT_W  = 51;   // dist >= 2072 keeps |d| * 2^30 / dist below 2^51
    localparam int PUSH_W  = 64;
    localparam int MOVE_W  = 34;

    // Arithmetic constants
    localparam logic [D2_W-1:0]   DIST2_FLOOR = 64'd4294967;
    localparam logic [DIST_W-1:0] DIST_MIN    = 32'd2072;
    localparam logic [MOVE_W-1:0] MOVE_CAP    = 34'h2_0000_0000;

    // Stage counts
    localparam int FRONT_LAT     = 4;
    localparam int SQRT_LAT      = 32;
    localparam int SHARE_DIV_LAT = SNUM_W;
    localparam int UNIT_DIV_LAT  = UNUM_W;
    localparam int PUSH_LAT      = 2;
    localparam int MOVE_LAT      = 4;
    localparam int OUT_LAT       = 1;
    localparam int PUSH_DLY      = UNIT_DIV_LAT - SHARE_DIV_LAT - PUSH_LAT;
    localparam int SIDE_DLY      = UNIT_DIV_LAT + MOVE_LAT;
    localparam int PIPE_LAT      = FRONT_LAT + SQRT_LAT + UNIT_DIV_LAT + MOVE_LAT + OUT_LAT;

    // Input beat, first field in the lowest bits
    typedef struct packed {
        logic              second_fixed;
        logic              first_fixed;
        logic [MASS_W-1:0] second_mass;
        logic [MASS_W-1:0] first_mass;
        logic [RAD_W-1:0]  second_radius;
        logic [RAD_W-1:0]  first_radius;
        logic [POS_W-1:0]  second_y;
        logic [POS_W-1:0]  second_x;
        logic [POS_W-1:0]  first_y;
        logic [POS_W-1:0]  first_x;
    } in_t;

    // Values carried to the output stage
    typedef struct packed {
        logic [POS_W-1:0] ax;
        logic [POS_W-1:0] ay;
        logic [POS_W-1:0] bx;
        logic [POS_W-1:0] by;
        logic             neg_x;
        logic             neg_y;
        logic             hit;
    } side_t;

    // Front-end results that feed the dividers
    typedef struct packed {
        side_t             side;
        logic [DIST_W-1:0] rs;
        logic [DIST_W-1:0] mx;
        logic [DIST_W-1:0] my;
        logic [MSUM_W-1:0] msum;
        logic [MASS_W-1:0] ma;
        logic [MASS_W-1:0] mb;
        logic              ok_a;
        logic              ok_b;
    } mid_t;

    typedef struct packed {
        logic [DIST_W-1:0] ovl;
        logic              ok_a;
        logic              ok_b;
    } ovl_t;

endpackage

`default_nettype wire

>>> sv/cpor_delay.sv
`default_nettype none

module cpor_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] din,
    output logic      [W-1:0] dout
);

    logic [W-1:0] pipe_reg [DEPTH];

    // Shift the line on each advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> sv/cpor_front.sv
`default_nettype none

module cpor_front (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire cpor_pkg::in_t                beat,
    output logic      [cpor_pkg::D2_W-1:0]    d2,
    output cpor_pkg::mid_t                    mid
);

    cpor_pkg::mid_t mid1_next, mid1_reg, mid2_reg, mid3_reg, mid4_next, mid4_reg;
    logic [cpor_pkg::D2_W-1:0] sx_reg, sy_reg, r2_reg, r2_3_reg;
    logic [cpor_pkg::D2_W-1:0] d2_3_next, d2_3_reg, d2_4_reg;

    // Stage 1: differences, magnitudes, radius and mass sums
    always_comb
    begin
        logic [32:0] dx;
        logic [32:0] dy;
        logic [32:0] dx_neg;
        logic [32:0] dy_neg;
        logic [cpor_pkg::MASS_W-1:0] ma_eff;
        logic [cpor_pkg::MASS_W-1:0] mb_eff;
        dx     = {beat.first_x[31], beat.first_x} - {beat.second_x[31], beat.second_x};
        dy     = {beat.first_y[31], beat.first_y} - {beat.second_y[31], beat.second_y};
        dx_neg = 33'd0 - dx;
        dy_neg = 33'd0 - dy;
        ma_eff = beat.first_fixed  ? '0 : beat.first_mass;
        mb_eff = beat.second_fixed ? '0 : beat.second_mass;
        mid1_next.side.ax    = beat.first_x;
        mid1_next.side.ay    = beat.first_y;
        mid1_next.side.bx    = beat.second_x;
        mid1_next.side.by    = beat.second_y;
        mid1_next.side.neg_x = dx[32];
        mid1_next.side.neg_y = dy[32];
        mid1_next.side.hit   = 1'b0;
        mid1_next.rs   = {1'b0, beat.first_radius} + {1'b0, beat.second_radius};
        mid1_next.mx   = dx[32] ? dx_neg[31:0] : dx[31:0];
        mid1_next.my   = dy[32] ? dy_neg[31:0] : dy[31:0];
        mid1_next.msum = {1'b0, ma_eff} + {1'b0, mb_eff};
        mid1_next.ma   = beat.first_mass;
        mid1_next.mb   = beat.second_mass;
        mid1_next.ok_a = !beat.first_fixed  && (mid1_next.msum != '0);
        mid1_next.ok_b = !beat.second_fixed && (mid1_next.msum != '0);
    end

    // Stage 3: saturate the squared length and apply the floor
    always_comb
    begin
        logic [cpor_pkg::D2_W:0]   sum;
        logic [cpor_pkg::D2_W-1:0] sat;
        sum = {1'b0, sx_reg} + {1'b0, sy_reg};
        sat = sum[cpor_pkg::D2_W] ? '1 : sum[cpor_pkg::D2_W-1:0];
        d2_3_next = (sat < cpor_pkg::DIST2_FLOOR) ? cpor_pkg::DIST2_FLOOR : sat;
    end

    // Stage 4: overlap test
    always_comb
    begin
        mid4_next          = mid3_reg;
        mid4_next.side.hit = d2_3_reg < r2_3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid1_reg <= mid1_next;
            // Stage 2: squares
            sx_reg   <= mid1_reg.mx * mid1_reg.mx;
            sy_reg   <= mid1_reg.my * mid1_reg.my;
            r2_reg   <= mid1_reg.rs * mid1_reg.rs;
            mid2_reg <= mid1_reg;
            d2_3_reg <= d2_3_next;
            r2_3_reg <= r2_reg;
            mid3_reg <= mid2_reg;
            d2_4_reg <= d2_3_reg;
            mid4_reg <= mid4_next;
        end
    end

    assign d2  = d2_4_reg;
    assign mid = mid4_reg;

endmodule

`default_nettype wire

>>> sv/cpor_sqrt.sv
`default_nettype none

module cpor_sqrt (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [cpor_pkg::D2_W-1:0]     d2,
    output logic      [cpor_pkg::DIST_W-1:0]   distance
);

    localparam int N = cpor_pkg::SQRT_LAT;

    logic [63:0] v_reg [N];
    logic [63:0] r_reg [N];
    logic [63:0] v_next [N];
    logic [63:0] r_next [N];

    // One result bit per stage, bit weight falls by four each stage
    always_comb
    begin
        logic [63:0] v_in;
        logic [63:0] r_in;
        logic [63:0] bit_w;
        logic [63:0] trial;
        for (int k = 0; k < N; k++)
        begin
            v_in  = (k == 0) ? d2 : v_reg[k-1];
            r_in  = (k == 0) ? 64'd0 : r_reg[k-1];
            bit_w = 64'd1 << (62 - 2 * k);
            trial = r_in + bit_w;
            if (v_in >= trial)
            begin
                v_next[k] = v_in - trial;
                r_next[k] = (r_in >> 1) + bit_w;
            end
            else
            begin
                v_next[k] = v_in;
                r_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                v_reg[k] <= v_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign distance = r_reg[N-1][cpor_pkg::DIST_W-1:0];

endmodule

`default_nettype wire

>>> sv/cpor_div.sv
`default_nettype none

module cpor_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33,
    parameter int Q_W   = 48
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quo
);

    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [Q_W-1:0]   q_reg   [NUM_W];
    logic [NUM_W-1:0] num_next [NUM_W];
    logic [DEN_W-1:0] rem_next [NUM_W];
    logic [Q_W-1:0]   q_next   [NUM_W];

    // Restoring division, one quotient bit per stage
    always_comb
    begin
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W-1:0] rem_in;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        for (int i = 0; i < NUM_W; i++)
        begin
            num_in = (i == 0) ? num : num_reg[i-1];
            den_in = (i == 0) ? den : den_reg[i-1];
            rem_in = (i == 0) ? '0  : rem_reg[i-1];
            q_in   = (i == 0) ? '0  : q_reg[i-1];
            trial  = {rem_in, num_in[NUM_W-1]};
            diff   = trial - {1'b0, den_in};
            num_next[i] = {num_in[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_in})
            begin
                rem_next[i] = diff[DEN_W-1:0];
                q_next[i]   = {q_in[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[DEN_W-1:0];
                q_next[i]   = {q_in[Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                num_reg[i] <= num_next[i];
                den_reg[i] <= (i == 0) ? den : den_reg[i-1];
                rem_reg[i] <= rem_next[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    assign quo = q_reg[NUM_W-1];

endmodule

`default_nettype wire

>>> sv/cpor_move.sv
`default_nettype none

module cpor_move (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [cpor_pkg::PUSH_W-1:0]   push,
    input  wire logic [cpor_pkg::UNIT_W-1:0]   unit,
    output logic      [cpor_pkg::MOVE_W-1:0]   mv
);

    localparam int UH_W  = cpor_pkg::UNIT_W - 32;
    localparam int PR_W  = cpor_pkg::PUSH_W + cpor_pkg::UNIT_W;

    logic [63:0]      ll_reg, hl_reg, ll2_reg;
    logic [32+UH_W-1:0] lh_reg, hh_reg, hh2_reg;
    logic [64:0]      mid_reg;
    logic [PR_W-1:0]  prod_reg;
    logic [cpor_pkg::MOVE_W-1:0] mv_next, mv_reg;

    // Scale by 2^-30 and cap
    always_comb
    begin
        if (prod_reg[PR_W-1:63] != '0)
        begin
            mv_next = cpor_pkg::MOVE_CAP;
        end
        else
        begin
            mv_next = {1'b0, prod_reg[62:30]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Partial products
            ll_reg   <= push[31:0]  * unit[31:0];
            lh_reg   <= push[31:0]  * unit[cpor_pkg::UNIT_W-1:32];
            hl_reg   <= push[63:32] * unit[31:0];
            hh_reg   <= push[63:32] * unit[cpor_pkg::UNIT_W-1:32];
            // Middle column
            mid_reg  <= {1'b0, hl_reg} + {{(65-32-UH_W){1'b0}}, lh_reg};
            ll2_reg  <= ll_reg;
            hh2_reg  <= hh_reg;
            // Full product
            prod_reg <= {hh2_reg, ll2_reg} + {{(PR_W-97){1'b0}}, mid_reg, 32'd0};
            mv_reg   <= mv_next;
        end
    end

    assign mv = mv_reg;

endmodule

`default_nettype wire

>>> sv/circle_pair_overlap_resolve_core.sv
// Depth: 103 register stages between an input beat and its result beat.
// Throughput: one pair per cycle while the output is not held; the 62-step direction divider sets the depth.
// The whole pipe advances together and holds only while an output beat waits.
// Reset clears the valid bits and the output valid; datapath registers keep no reset.
`default_nettype none

module circle_pair_overlap_resolve_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // first_x, first_y, second_x, second_y, first_radius, second_radius,
    // first_mass, second_mass, first_fixed, second_fixed
    input  wire logic [255:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // new_first_x, new_first_y, new_second_x, new_second_y, overlapped, zero pad
    output logic      [135:0] m_axis_tdata
);

    localparam int LAT = cpor_pkg::PIPE_LAT;
    localparam int T0  = cpor_pkg::FRONT_LAT + cpor_pkg::SQRT_LAT;

    logic                            en;
    logic [LAT-1:0]                  vld_reg;
    cpor_pkg::in_t                   beat;
    logic [cpor_pkg::D2_W-1:0]       d2_f;
    cpor_pkg::mid_t                  mid_f, mid_t0;
    logic [cpor_pkg::DIST_W-1:0]     distance;
    cpor_pkg::ovl_t                  ovl_t0, ovl_d;
    logic [cpor_pkg::UNIT_W-1:0]     unit_x, unit_y;
    logic [cpor_pkg::SHARE_W-1:0]    qa, qb, sa, sb;
    logic [63:0]                     pa0_reg, pb0_reg;
    logic [47:0]                     pa1_reg, pb1_reg;
    logic [cpor_pkg::PUSH_W-1:0]     push_a_next, push_b_next, push_a_reg, push_b_reg;
    logic [cpor_pkg::PUSH_W-1:0]     push_a, push_b;
    cpor_pkg::side_t                 side_d;
    logic [cpor_pkg::MOVE_W-1:0]     mv_ax, mv_ay, mv_bx, mv_by;
    logic [135:0]                    out_next, out_reg;

    // Advance when the output register is free or being taken
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = out_reg;
    assign beat          = cpor_pkg::in_t'(s_axis_tdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    cpor_front u_front (
        .clk  (clk),
        .en   (en),
        .beat (beat),
        .d2   (d2_f),
        .mid  (mid_f)
    );

    cpor_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .d2       (d2_f),
        .distance (distance)
    );

    cpor_delay #(.W($bits(cpor_pkg::mid_t)), .DEPTH(cpor_pkg::SQRT_LAT)) u_mid_dly (
        .clk  (clk),
        .en   (en),
        .din  (mid_f),
        .dout (mid_t0)
    );

    // Unit direction magnitudes
    cpor_div #(.NUM_W(cpor_pkg::UNUM_W), .DEN_W(cpor_pkg::DIST_W),
               .Q_W(cpor_pkg::UNIT_W)) u_div_ux (
        .clk (clk),
        .en  (en),
        .num ({mid_t0.mx, 30'd0}),
        .den (distance),
        .quo (unit_x)
    );

    cpor_div #(.NUM_W(cpor_pkg::UNUM_W), .DEN_W(cpor_pkg::DIST_W),
               .Q_W(cpor_pkg::UNIT_W)) u_div_uy (
        .clk (clk),
        .en  (en),
        .num ({mid_t0.my, 30'd0}),
        .den (distance),
        .quo (unit_y)
    );

    // Mass shares
    cpor_div #(.NUM_W(cpor_pkg::SNUM_W), .DEN_W(cpor_pkg::MSUM_W),
               .Q_W(cpor_pkg::SHARE_W)) u_div_sa (
        .clk (clk),
        .en  (en),
        .num ({mid_t0.mb, 16'd0}),
        .den (mid_t0.msum),
        .quo (qa)
    );

    cpor_div #(.NUM_W(cpor_pkg::SNUM_W), .DEN_W(cpor_pkg::MSUM_W),
               .Q_W(cpor_pkg::SHARE_W)) u_div_sb (
        .clk (clk),
        .en  (en),
        .num ({mid_t0.ma, 16'd0}),
        .den (mid_t0.msum),
        .quo (qb)
    );

    // Overlap depth waits for the shares
    always_comb
    begin
        ovl_t0.ovl  = mid_t0.rs - distance;
        ovl_t0.ok_a = mid_t0.ok_a;
        ovl_t0.ok_b = mid_t0.ok_b;
    end

    cpor_delay #(.W($bits(cpor_pkg::ovl_t)), .DEPTH(cpor_pkg::SHARE_DIV_LAT)) u_ovl_dly (
        .clk  (clk),
        .en   (en),
        .din  (ovl_t0),
        .dout (ovl_d)
    );

    assign sa = ovl_d.ok_a ? qa : '0;
    assign sb = ovl_d.ok_b ? qb : '0;

    // Push = overlap * share / 2^16
    always_comb
    begin
        logic [79:0] sum_a;
        logic [79:0] sum_b;
        sum_a = {pa1_reg, 32'd0} + {16'd0, pa0_reg};
        sum_b = {pb1_reg, 32'd0} + {16'd0, pb0_reg};
        push_a_next = sum_a[79:16];
        push_b_next = sum_b[79:16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa0_reg    <= ovl_d.ovl * sa[31:0];
            pa1_reg    <= ovl_d.ovl * sa[47:32];
            pb0_reg    <= ovl_d.ovl * sb[31:0];
            pb1_reg    <= ovl_d.ovl * sb[47:32];
            push_a_reg <= push_a_next;
            push_b_reg <= push_b_next;
        end
    end

    cpor_delay #(.W(2 * cpor_pkg::PUSH_W), .DEPTH(cpor_pkg::PUSH_DLY)) u_push_dly (
        .clk  (clk),
        .en   (en),
        .din  ({push_a_reg, push_b_reg}),
        .dout ({push_a, push_b})
    );

    cpor_delay #(.W($bits(cpor_pkg::side_t)), .DEPTH(cpor_pkg::SIDE_DLY)) u_side_dly (
        .clk  (clk),
        .en   (en),
        .din  (mid_t0.side),
        .dout (side_d)
    );

    cpor_move u_move_ax (.clk(clk), .en(en), .push(push_a), .unit(unit_x), .mv(mv_ax));
    cpor_move u_move_ay (.clk(clk), .en(en), .push(push_a), .unit(unit_y), .mv(mv_ay));
    cpor_move u_move_bx (.clk(clk), .en(en), .push(push_b), .unit(unit_x), .mv(mv_bx));
    cpor_move u_move_by (.clk(clk), .en(en), .push(push_b), .unit(unit_y), .mv(mv_by));

    function automatic logic [31:0] apply_move(input logic [31:0] pos,
                                               input logic [cpor_pkg::MOVE_W-1:0] mv,
                                               input logic neg);
        logic signed [35:0] base;
        logic signed [35:0] step;
        logic signed [35:0] sum;
        logic [31:0]        res;
        base = 36'($signed(pos));
        step = $signed({2'b00, mv});
        sum  = neg ? (base - step) : (base + step);
        if (sum > 36'sh0_7FFF_FFFF)
        begin
            res = 32'h7FFF_FFFF;
        end
        else if (sum < 36'shF_8000_0000)
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = sum[31:0];
        end
        return res;
    endfunction

    // Apply moves on overlap, pass positions through otherwise
    always_comb
    begin
        out_next = '0;
        if (side_d.hit)
        begin
            out_next[31:0]   = apply_move(side_d.ax, mv_ax, side_d.neg_x);
            out_next[63:32]  = apply_move(side_d.ay, mv_ay, side_d.neg_y);
            out_next[95:64]  = apply_move(side_d.bx, mv_bx, !side_d.neg_x);
            out_next[127:96] = apply_move(side_d.by, mv_by, !side_d.neg_y);
            out_next[128]    = 1'b1;
        end
        else
        begin
            out_next[31:0]   = side_d.ax;
            out_next[63:32]  = side_d.ay;
            out_next[95:64]  = side_d.bx;
            out_next[127:96] = side_d.by;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    // The distance floor must survive the square root
    a_dist_floor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[T0-1] |-> (distance >= cpor_pkg::DIST_MIN))
        else $error("distance below floor");

    // Moves never exceed the cap
    a_move_cap: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT-2] |-> (mv_ax <= cpor_pkg::MOVE_CAP) && (mv_ay <= cpor_pkg::MOVE_CAP)
                        && (mv_bx <= cpor_pkg::MOVE_CAP) && (mv_by <= cpor_pkg::MOVE_CAP))
        else $error("move above cap");

    // A pair without overlap leaves unchanged
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[LAT-2] && !side_d.hit) |=>
            (m_axis_tdata[31:0] == $past(side_d.ax)) && (m_axis_tdata[95:64] == $past(side_d.bx))
            && (m_axis_tdata[63:32] == $past(side_d.ay))
            && (m_axis_tdata[127:96] == $past(side_d.by)) && !m_axis_tdata[128])
        else $error("positions changed without overlap");

    // A held pipe keeps its occupancy
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

endmodule

`default_nettype wire

>>> verif/tb_circle_pair_overlap_resolve_core.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_circle_pair_overlap_resolve_core;

    // Expected corrected positions for one pair
    typedef struct packed {
        logic [31:0] nax;
        logic [31:0] nay;
        logic [31:0] nbx;
        logic [31:0] nby;
        logic        hit;
    } pair_res_t;

    // Q-format helpers for the correction predictor
    function automatic logic [63:0] mul_shr_sat(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        begin
            p = (128'(a) * 128'(b)) >> s;
            mul_shr_sat = (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
        end
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        begin
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            int_sqrt = r;
        end
    endfunction

    function automatic logic [31:0] shift_pos(logic signed [31:0] pos, logic [63:0] mv,
                                              bit neg);
        logic signed [65:0] v;
        begin
            v = neg ? 66'(pos) - $signed({2'b0, mv}) : 66'(pos) + $signed({2'b0, mv});
            if (v > 66'sd2147483647)
                v = 66'sd2147483647;
            if (v < -66'sd2147483648)
                v = -66'sd2147483648;
            shift_pos = v[31:0];
        end
    endfunction

    function automatic logic [63:0] axis_move(logic [63:0] push, logic [63:0] dm,
                                              logic [63:0] distance);
        logic [63:0] u;
        logic [63:0] mv;
        begin
            u = (dm << 30) / distance;
            mv = mul_shr_sat(push, u, 30);
            axis_move = (mv > 64'(cpor_pkg::MOVE_CAP)) ? 64'(cpor_pkg::MOVE_CAP) : mv;
        end
    endfunction

    function automatic pair_res_t resolve_pair(cpor_pkg::in_t p);
        pair_res_t r;
        logic signed [63:0] dx, dy;
        logic [63:0] mx, my, sx, d2, rs, r2, distance, ovl, msum, sa, sb, pa, pb;
        begin
            dx = $signed(p.first_x) - $signed(p.second_x);
            dy = $signed(p.first_y) - $signed(p.second_y);
            mx = dx < 0 ? -dx : dx;
            my = dy < 0 ? -dy : dy;
            sx = mx * mx;
            d2 = sx + my * my;
            rs = 64'(p.first_radius) + 64'(p.second_radius);
            r2 = rs * rs;
            if (d2 < sx)
                d2 = 64'hFFFF_FFFF_FFFF_FFFF;
            if (d2 < cpor_pkg::DIST2_FLOOR)
                d2 = cpor_pkg::DIST2_FLOOR;
            r = '{p.first_x, p.first_y, p.second_x, p.second_y, 1'b0};
            if (d2 < r2)
            begin
                distance = int_sqrt(d2);
                ovl = rs - distance;
                msum = (p.first_fixed ? 64'd0 : 64'(p.first_mass))
                     + (p.second_fixed ? 64'd0 : 64'(p.second_mass));
                sa = 0;
                sb = 0;
                if (msum != 0)
                begin
                    if (!p.first_fixed)
                        sa = (64'(p.second_mass) << 16) / msum;
                    if (!p.second_fixed)
                        sb = (64'(p.first_mass) << 16) / msum;
                end
                pa = mul_shr_sat(ovl, sa, 16);
                pb = mul_shr_sat(ovl, sb, 16);
                r.nax = shift_pos(p.first_x, axis_move(pa, mx, distance), dx < 0);
                r.nay = shift_pos(p.first_y, axis_move(pa, my, distance), dy < 0);
                r.nbx = shift_pos(p.second_x, axis_move(pb, mx, distance), !(dx < 0));
                r.nby = shift_pos(p.second_y, axis_move(pb, my, distance), !(dy < 0));
                r.hit = 1'b1;
            end
            resolve_pair = r;
        end
    endfunction

    // Scoreboard of pending corrections
    class pair_scoreboard;
        pair_res_t pending[$];
        int        errors;
        int        checked;
        int        hits;

        function void note_pair(cpor_pkg::in_t p);
            pending.push_back(resolve_pair(p));
        endfunction

        function void check_beat(logic [135:0] d);
            pair_res_t got;
            pair_res_t exp_r;
            got = '{d[31:0], d[63:32], d[95:64], d[127:96], d[128]};
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, d);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            checked++;
            if (got.hit)
                hits++;
            if (got.nax !== exp_r.nax)
                $display("%0t: new_first_x exp %h got %h", $time, exp_r.nax, got.nax);
            if (got.nay !== exp_r.nay)
                $display("%0t: new_first_y exp %h got %h", $time, exp_r.nay, got.nay);
            if (got.nbx !== exp_r.nbx)
                $display("%0t: new_second_x exp %h got %h", $time, exp_r.nbx, got.nbx);
            if (got.nby !== exp_r.nby)
                $display("%0t: new_second_y exp %h got %h", $time, exp_r.nby, got.nby);
            if (got.hit !== exp_r.hit)
                $display("%0t: overlapped exp %b got %b", $time, exp_r.hit, got.hit);
            if (got !== exp_r || d[135:129] !== 7'd0)
                errors++;
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;

    pair_scoreboard sb = new();
    int  send_idle_pct = 31;
    int  recv_idle_pct = 84;
    int  idle_cycles = 0;

    always #1 clk = ~clk;

    circle_pair_overlap_resolve_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Receive side: random stall, check each accepted beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive one beat, honoring the sender idle rate; valid stays up for the next beat
    task automatic send_pair(cpor_pkg::in_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= 256'(p);
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pair(p);
    endtask

    // Random pair; mostly near neighbors so overlaps are common
    function automatic cpor_pkg::in_t rand_pair();
        cpor_pkg::in_t p;
        int  k;
        begin
            k = $urandom_range(9);
            p.first_x = $urandom();
            p.first_y = $urandom();
            if (k < 7)
            begin
                p.second_x = p.first_x + ($urandom() >>> $urandom_range(31, 8)) - 32'h80_0000;
                p.second_y = p.first_y + ($urandom() >>> $urandom_range(31, 8)) - 32'h80_0000;
                p.first_radius = 31'($urandom() >> $urandom_range(24, 1));
                p.second_radius = 31'($urandom() >> $urandom_range(24, 1));
            end
            else
            begin
                p.second_x = $urandom();
                p.second_y = $urandom();
                p.first_radius = 31'($urandom());
                p.second_radius = 31'($urandom());
            end
            p.first_mass = $urandom() >> $urandom_range(31);
            p.second_mass = $urandom() >> $urandom_range(31);
            p.first_fixed = ($urandom_range(4) == 0);
            p.second_fixed = ($urandom_range(4) == 0);
            rand_pair = p;
        end
    endfunction

    function automatic cpor_pkg::in_t mk(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                               logic [31:0] by, logic [30:0] ra, logic [30:0] rb,
                               logic [31:0] ma, logic [31:0] mb, bit fa, bit fb);
        mk = '{fb, fa, mb, ma, rb, ra, by, bx, ay, ax};
    endfunction

    task automatic run_directed();
        // coincident centers, close centers, axis-aligned
        send_pair(mk(0, 0, 0, 0, 31'h1_0000, 31'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0));
        send_pair(mk(5, 3, 4, 3, 31'h8000, 31'h8000, 32'h2_0000, 32'h1_0000, 0, 0));
        send_pair(mk(32'h1_0000, 0, 0, 0, 31'h1_0000, 31'h1_0000, 32'h1_0000, 32'h3_0000,
                     0, 0));
        send_pair(mk(0, 32'hFFFF_0000, 0, 0, 31'h1_0000, 31'h8000, 32'h1_0000, 32'h1_0000,
                     0, 0));
        // no overlap
        send_pair(mk(32'h10_0000, 32'h10_0000, 0, 0, 31'h1_0000, 31'h1_0000, 1, 1, 0, 0));
        // both pinned, zero mass sum, one pinned
        send_pair(mk(32'h1000, 32'h2000, 0, 0, 31'h1_0000, 31'h1_0000, 5, 7, 1, 1));
        send_pair(mk(32'h1000, 32'h2000, 0, 0, 31'h1_0000, 31'h1_0000, 0, 0, 0, 0));
        send_pair(mk(32'h1000, 32'h2000, 0, 0, 31'h1_0000, 31'h1_0000, 32'hFFFF_FFFF, 1,
                     0, 1));
        send_pair(mk(32'h1000, 32'h2000, 0, 0, 31'h1_0000, 31'h1_0000, 1, 32'hFFFF_FFFF,
                     1, 0));
        // extremes: huge radii and opposite corners, saturation
        send_pair(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        send_pair(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0));
        send_pair(mk(32'h7FFF_FFF0, 32'h10, 32'h7FFF_FF00, 0, 31'h7FFF_FFFF, 0, 1, 1,
                     0, 0));
        send_pair(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
        send_pair(mk(32'h100, 32'h8000_0000, 32'h200, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_pair(rand_pair());
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(500);
        // hold the sender until the pipe empties
        drain();
        send_idle_pct = 84;
        recv_idle_pct = 31;
        run_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(540);
        drain();
        repeat (120) @(posedge clk);
        $display("Checked %0d pair corrections, %0d with overlap, under three stall mixes.",
                 sb.checked, sb.hits);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
